FILE: design/pat_pkg.sv
package pat_pkg;

    localparam int NUM_SLOTS = 8;
    localparam int SLOT_W = 3;
    localparam int TIME_W = 48;
    localparam int PERIOD_W = 32;
    localparam int MAX_FIRES = 64;
    localparam int FIRE_CNT_W = $clog2(MAX_FIRES);
    localparam logic [PERIOD_W-1:0] FRAME_RESET = PERIOD_W'(486000000 / 4 / 60);

    // Operation of the shared adder.
    typedef enum logic [1:0] {
        U_ADD = 2'b01,
        U_CMP = 2'b10
    } t_unit_op;

    typedef struct packed {
        t_unit_op             op;
        logic [TIME_W-1:0]    a;
        logic [TIME_W-1:0]    b;
    } t_unit_req;

endpackage

FILE: design/pat_unit.sv
module pat_unit import pat_pkg::*; (
    input  t_unit_req          i_req,
    output logic [TIME_W-1:0]  o_sum,
    output logic               o_ge
);

    logic [TIME_W-1:0] w_b;
    logic [TIME_W:0]   w_full;

    // Compare is a - b done as a + ~b + 1; the carry out means a >= b.
    // Add saturates at all ones when the carry comes out.
    always_comb begin
        w_b = (i_req.op == U_CMP) ? ~i_req.b : i_req.b;
        w_full = {1'b0, i_req.a} + {1'b0, w_b}
                 + {{TIME_W{1'b0}}, (i_req.op == U_CMP)};
        o_ge = w_full[TIME_W];
        if (i_req.op == U_ADD && w_full[TIME_W]) begin
            o_sum = {TIME_W{1'b1}};
        end else begin
            o_sum = w_full[TIME_W-1:0];
        end
    end

endmodule

FILE: design/periodic_alarm_timer.sv
// Periodic alarm timer with eight slots.
// Command channel: a word is taken at a clock edge with i_start high and o_busy low.
// i_cmd selects arm (slot, fire time, period), cancel, advance by i_step, or
// advance by the frame period. Configuration: one write channel carrying the
// frame period; a write of zero is dropped. o_cfg_ready is high while idle.
// Results: each result word is on the o_ ports for one cycle, marked by o_valid,
// and the receiver cannot hold it off. o_last marks the final word of a command.
// Arm, cancel and frame advance give one word, which the execute state registers
// once the command is taken. A step advance scans the recency order
// one slot per cycle through the single shared 48-bit adder/comparator, until an
// armed slot is due; each firing then restarts the scan from the front, and at
// most 64 firings are handled per step. Each firing word comes out once the
// following scan has shown whether it is the last, or at once at the 64th firing.
// A new command is taken only when the previous one is finished (o_busy low).
// Reset clears the time, the armed bits, and restores the ascending slot order
// and the default frame period; slot times and periods are undefined until armed.
module periodic_alarm_timer import pat_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [1:0]           i_cmd,
    input  logic [SLOT_W-1:0]    i_slot,
    input  logic [TIME_W-1:0]    i_fire_time,
    input  logic [PERIOD_W-1:0]  i_repeat_period,
    input  logic [PERIOD_W-1:0]  i_step,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [PERIOD_W-1:0]  i_cfg_data,
    output logic                 o_valid,
    output logic                 o_fired,
    output logic [SLOT_W-1:0]    o_fired_slot,
    output logic                 o_last,
    output logic [TIME_W-1:0]    o_now_time,
    output logic [NUM_SLOTS-1:0] o_armed_mask
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_SCAN = 4'b0100,
        S_FIRE = 4'b1000
    } t_state;

    typedef enum logic [1:0] {
        C_ARM    = 2'd0,
        C_CANCEL = 2'd1,
        C_STEP   = 2'd2,
        C_FRAME  = 2'd3
    } t_cmd;

    t_state                r_state;
    t_cmd                  r_cmd;
    logic [SLOT_W-1:0]     r_slot;
    logic [TIME_W-1:0]     r_fire_in;
    logic [PERIOD_W-1:0]   r_per_in;
    logic [PERIOD_W-1:0]   r_step;
    logic [PERIOD_W-1:0]   r_frame;
    logic [TIME_W-1:0]     r_time;
    logic [TIME_W-1:0]     r_fire [NUM_SLOTS];
    logic [PERIOD_W-1:0]   r_period [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]  r_armed;
    logic [SLOT_W-1:0]     r_order [NUM_SLOTS];
    logic [SLOT_W-1:0]     r_pos;
    logic [SLOT_W-1:0]     r_hit;
    logic [FIRE_CNT_W-1:0] r_cnt;
    logic                  r_pend;
    logic [SLOT_W-1:0]     r_pend_slot;
    logic [NUM_SLOTS-1:0]  r_pend_mask;

    logic                  r_out_valid;
    logic                  r_out_fired;
    logic [SLOT_W-1:0]     r_out_slot;
    logic                  r_out_last;
    logic [TIME_W-1:0]     r_out_time;
    logic [NUM_SLOTS-1:0]  r_out_mask;

    logic [NUM_SLOTS-1:0]  n_armed;
    logic [TIME_W-1:0]     n_time;
    logic [SLOT_W-1:0]     n_order [NUM_SLOTS];

    logic [SLOT_W-1:0]     w_addr;
    logic [TIME_W-1:0]     w_rd_fire;
    logic [PERIOD_W-1:0]   w_rd_period;
    t_unit_req             w_req;
    logic [TIME_W-1:0]     w_sum;
    logic                  w_ge;
    logic                  w_hit;
    logic                  w_in_range;
    logic [SLOT_W-1:0]     w_front_slot;
    logic [SLOT_W-1:0]     w_front_pos;
    logic [NUM_SLOTS-1:0]  w_order_seen;

    assign o_busy = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);

    assign o_valid      = r_out_valid;
    assign o_fired      = r_out_fired;
    assign o_fired_slot = r_out_slot;
    assign o_last       = r_out_last;
    assign o_now_time   = r_out_time;
    assign o_armed_mask = r_out_mask;

    // One read port into the slot table: the scan position, or the slot being fired.
    assign w_addr      = (r_state == S_FIRE) ? r_hit : r_order[r_pos];
    assign w_rd_fire   = r_fire[w_addr];
    assign w_rd_period = r_period[w_addr];
    assign w_in_range  = ({1'b0, r_slot} < (SLOT_W + 1)'(NUM_SLOTS));

    always_comb begin
        w_req.op = U_ADD;
        w_req.a  = r_time;
        w_req.b  = '0;
        case (r_state)
            S_EXEC: begin
                w_req.b = (r_cmd == C_FRAME) ? TIME_W'(r_frame) : TIME_W'(r_step);
            end
            S_SCAN: begin
                w_req.op = U_CMP;
                w_req.b  = w_rd_fire;
            end
            S_FIRE: begin
                w_req.a = w_rd_fire;
                w_req.b = TIME_W'(w_rd_period);
            end
            default: begin
                w_req.b = '0;
            end
        endcase
    end

    pat_unit u_unit (
        .i_req (w_req),
        .o_sum (w_sum),
        .o_ge  (w_ge)
    );

    assign w_hit = r_armed[w_addr] & w_ge;

    // Move a slot to the front of the recency order: entries ahead of it shift down by one.
    assign w_front_slot = (r_state == S_FIRE) ? r_hit : r_slot;

    always_comb begin
        w_front_pos = SLOT_W'(NUM_SLOTS - 1);
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (r_order[i] == w_front_slot) begin
                w_front_pos = SLOT_W'(i);
            end
        end
        n_order[0] = w_front_slot;
        for (int i = 1; i < NUM_SLOTS; i++) begin
            if (SLOT_W'(i) <= w_front_pos) begin
                n_order[i] = r_order[i-1];
            end else begin
                n_order[i] = r_order[i];
            end
        end
    end

    always_comb begin
        n_armed = r_armed;
        n_time  = r_time;
        if (r_state == S_EXEC) begin
            case (r_cmd)
                C_ARM: begin
                    if (w_in_range) begin
                        n_armed[r_slot] = 1'b1;
                    end
                end
                C_CANCEL: begin
                    if (w_in_range) begin
                        n_armed[r_slot] = 1'b0;
                    end
                end
                C_STEP, C_FRAME: begin
                    n_time = w_sum;
                end
                default: begin
                    n_time = r_time;
                end
            endcase
        end else if (r_state == S_FIRE && w_rd_period == '0) begin
            n_armed[r_hit] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_time      <= '0;
            r_frame     <= FRAME_RESET;
            r_armed     <= '0;
            r_pos       <= '0;
            r_hit       <= '0;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_pend_slot <= '0;
            r_pend_mask <= '0;
            r_out_valid <= 1'b0;
            r_out_fired <= 1'b0;
            r_out_slot  <= '0;
            r_out_last  <= 1'b0;
            r_out_time  <= '0;
            r_out_mask  <= '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_order[i] <= SLOT_W'(i);
            end
        end else begin
            r_out_valid <= 1'b0;
            r_armed     <= n_armed;
            r_time      <= n_time;
            if (i_cfg_valid && o_cfg_ready && i_cfg_data != '0) begin
                r_frame <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (r_cmd == C_STEP) begin
                        r_pos   <= '0;
                        r_cnt   <= '0;
                        r_pend  <= 1'b0;
                        r_state <= S_SCAN;
                    end else begin
                        if (r_cmd == C_ARM && w_in_range) begin
                            r_order <= n_order;
                        end
                        r_out_valid <= 1'b1;
                        r_out_fired <= 1'b0;
                        r_out_slot  <= '0;
                        r_out_last  <= 1'b1;
                        r_out_time  <= n_time;
                        r_out_mask  <= n_armed;
                        r_state     <= S_IDLE;
                    end
                end
                S_SCAN: begin
                    if (w_hit) begin
                        // Another firing follows, so the held word is not the last.
                        if (r_pend) begin
                            r_out_valid <= 1'b1;
                            r_out_fired <= 1'b1;
                            r_out_slot  <= r_pend_slot;
                            r_out_last  <= 1'b0;
                            r_out_time  <= r_time;
                            r_out_mask  <= r_pend_mask;
                        end
                        r_hit   <= w_addr;
                        r_state <= S_FIRE;
                    end else if (r_pos == SLOT_W'(NUM_SLOTS - 1)) begin
                        r_out_valid <= 1'b1;
                        r_out_fired <= r_pend;
                        r_out_slot  <= r_pend ? r_pend_slot : '0;
                        r_out_last  <= 1'b1;
                        r_out_time  <= r_time;
                        r_out_mask  <= r_pend ? r_pend_mask : r_armed;
                        r_pend      <= 1'b0;
                        r_state     <= S_IDLE;
                    end else begin
                        r_pos <= r_pos + 1'b1;
                    end
                end
                S_FIRE: begin
                    if (w_rd_period != '0) begin
                        r_order <= n_order;
                    end
                    r_cnt <= r_cnt + 1'b1;
                    r_pos <= '0;
                    if (r_cnt == FIRE_CNT_W'(MAX_FIRES - 1)) begin
                        r_out_valid <= 1'b1;
                        r_out_fired <= 1'b1;
                        r_out_slot  <= r_hit;
                        r_out_last  <= 1'b1;
                        r_out_time  <= r_time;
                        r_out_mask  <= n_armed;
                        r_pend      <= 1'b0;
                        r_state     <= S_IDLE;
                    end else begin
                        r_pend      <= 1'b1;
                        r_pend_slot <= r_hit;
                        r_pend_mask <= n_armed;
                        r_state     <= S_SCAN;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Command word and slot table.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_cmd     <= t_cmd'(i_cmd);
            r_slot    <= i_slot;
            r_fire_in <= i_fire_time;
            r_per_in  <= i_repeat_period;
            r_step    <= i_step;
        end
        if (r_state == S_EXEC && r_cmd == C_ARM && w_in_range) begin
            r_fire[r_slot]   <= r_fire_in;
            r_period[r_slot] <= r_per_in;
        end else if (r_state == S_FIRE && w_rd_period != '0) begin
            r_fire[r_hit] <= w_sum;
        end
    end

    always_comb begin
        w_order_seen = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            w_order_seen[r_order[i]] = 1'b1;
        end
    end

    a_order_perm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        &w_order_seen)
        else $error("recency order is not a permutation of the slots");

    a_quiet_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_fired) |-> (o_last && o_fired_slot == '0))
        else $error("word without a firing is not a lone final word");

    a_valid_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_state) != S_IDLE))
        else $error("result word without a command in progress");

    a_fire_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIRE) |-> r_armed[r_hit])
        else $error("firing a slot that is not armed");

endmodule
